### rtl/signed_int_to_decimal_ascii_core_macros.svh
// Assertion macros shared by the signed integer to decimal text RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle
`define SITOA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sitoa: same-cycle check failed");
// Antecedent implies consequent in the next cycle
`define SITOA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sitoa: next-cycle check failed");
`else
`define SITOA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SITOA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/sitoa_pkg.sv
// Shared widths, character codes and a helper function for the
// signed integer to decimal text core. No dependencies.
`default_nettype none

package sitoa_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned DIG_CNT = 10;
    localparam int unsigned BCD_W   = DIG_CNT * 4;
    localparam int unsigned CODE_W  = 6;
    localparam int unsigned CNT_W   = 5;

    localparam logic [CODE_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CODE_W-1:0] CHAR_ZERO  = 6'd48;

    // Counter start values: one step per input bit, one per BCD digit
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(DATA_W - 1);
    localparam logic [CNT_W-1:0] LAST_DIG = CNT_W'(DIG_CNT - 1);

    // Correct one BCD digit ahead of a left shift
    function automatic logic [3:0] add3(input logic [3:0] d);
        return (d >= 4'd5) ? (d + 4'd3) : d;
    endfunction

endpackage

`default_nettype wire

### rtl/sitoa_dd_step.sv
// One shift-and-add-3 step of binary to BCD conversion.
// Depends on sitoa_pkg.
`default_nettype none

module sitoa_dd_step (
    input  wire logic [sitoa_pkg::BCD_W-1:0]  i_bcd,
    input  wire logic [sitoa_pkg::DATA_W-1:0] i_bin,
    output logic      [sitoa_pkg::BCD_W-1:0]  o_bcd,
    output logic      [sitoa_pkg::DATA_W-1:0] o_bin
);

    logic [sitoa_pkg::BCD_W-1:0] adj;

    // Correct every digit, then shift the next binary bit into the BCD word
    always_comb begin
        for (int k = 0; k < sitoa_pkg::DIG_CNT; k++) begin
            adj[4*k +: 4] = sitoa_pkg::add3(i_bcd[4*k +: 4]);
        end
        {o_bcd, o_bin} = {adj[sitoa_pkg::BCD_W-2:0], i_bin, 1'b0};
    end

endmodule

`default_nettype wire

### rtl/signed_int_to_decimal_ascii_core.sv
// Signed 32-bit integer to decimal ASCII text. Each accepted value produces
// 1 to 11 character beats, most significant first: a leading '-' for negative
// values, then the digits with leading zeros dropped; the final beat has o_last
// set. The core takes one value at a time and holds o_stall high until its last
// character has been loaded into the output register. Each value is accepted,
// run through the shared shift-and-add-3 unit one step per input bit, stripped
// of leading zeros, then handed to the output at one character per cycle while
// the output side is not stalled.
// Depends on sitoa_pkg, sitoa_dd_step and the macro header.
`default_nettype none

`include "signed_int_to_decimal_ascii_core_macros.svh"

module signed_int_to_decimal_ascii_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // input channel
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic signed [sitoa_pkg::DATA_W-1:0]   i_value,
    // output channel
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic             [sitoa_pkg::CODE_W-1:0]   o_char_code,
    output logic                                       o_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } t_state;

    t_state                          r_state,  n_state;
    logic [sitoa_pkg::DATA_W-1:0]    r_bin,    n_bin;
    logic [sitoa_pkg::BCD_W-1:0]     r_bcd,    n_bcd;
    logic [sitoa_pkg::CNT_W-1:0]     r_cnt,    n_cnt;
    logic                            r_neg,    n_neg;
    logic                            r_valid,  n_valid;
    logic [sitoa_pkg::CODE_W-1:0]    r_char,   n_char;
    logic                            r_last,   n_last;

    logic [sitoa_pkg::BCD_W-1:0]     step_bcd;
    logic [sitoa_pkg::DATA_W-1:0]    step_bin;
    logic [3:0]                      top_dig;
    logic                            out_free;

    sitoa_dd_step u_step (
        .i_bcd (r_bcd),
        .i_bin (r_bin),
        .o_bcd (step_bcd),
        .o_bin (step_bin)
    );

    assign top_dig  = r_bcd[sitoa_pkg::BCD_W-1 -: 4];
    assign out_free = !r_valid || !i_stall;

    // Sequence conversion, leading-zero drop and character output
    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_valid = r_valid;
        n_char  = r_char;
        n_last  = r_last;

        // drop the output beat once it is taken
        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_neg   = i_value[sitoa_pkg::DATA_W-1];
                    n_bin   = i_value[sitoa_pkg::DATA_W-1] ? (~i_value + 1'b1) : i_value;
                    n_bcd   = '0;
                    n_cnt   = sitoa_pkg::LAST_BIT;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd = step_bcd;
                n_bin = step_bin;
                if (r_cnt == '0) begin
                    n_cnt   = sitoa_pkg::LAST_DIG;
                    n_state = ST_SKIP;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_SKIP: begin
                if (top_dig == 4'd0 && r_cnt != '0) begin
                    n_bcd = {r_bcd[sitoa_pkg::BCD_W-5:0], 4'd0};
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    n_valid = 1'b1;
                    n_char  = sitoa_pkg::CHAR_MINUS;
                    n_last  = 1'b0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_valid = 1'b1;
                    n_char  = sitoa_pkg::CHAR_ZERO + {2'b00, top_dig};
                    n_last  = (r_cnt == '0);
                    n_bcd   = {r_bcd[sitoa_pkg::BCD_W-5:0], 4'd0};
                    if (r_cnt == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

    // Checks
    `SITOA_ASSERT_NXT(a_accept_starts_conv, i_clk, i_rst_n,
        i_valid && !o_stall,
        (r_state == ST_CONV) && (r_cnt == sitoa_pkg::LAST_BIT))
    `SITOA_ASSERT_IMP(a_char_in_range, i_clk, i_rst_n,
        o_valid,
        (o_char_code == sitoa_pkg::CHAR_MINUS) ||
        ((o_char_code >= sitoa_pkg::CHAR_ZERO) &&
         (o_char_code <= sitoa_pkg::CHAR_ZERO + 6'd9)))
    `SITOA_ASSERT_IMP(a_minus_not_last, i_clk, i_rst_n,
        o_valid && (o_char_code == sitoa_pkg::CHAR_MINUS),
        !o_last)

endmodule

`default_nettype wire
